/* rtl/core/lpht_pkg.sv */
package lpht_pkg;

    localparam int SLOTS       = 1024;
    localparam int ITEM_BITS   = 32;

    localparam int HASH_W      = 64;
    localparam int IN_ITEM_W   = 32;
    localparam int OUT_ITEM_W  = 32;
    localparam int FUNC_W      = 3;
    localparam int LIMIT_W     = 11;
    localparam int COUNT_OUT_W = 11;

    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int CMP_W       = (CNT_W + 1 > LIMIT_W) ? CNT_W + 1 : LIMIT_W;
    localparam int ITEM_W      = (ITEM_BITS < IN_ITEM_W) ? ITEM_BITS : IN_ITEM_W;
    localparam bit SLOTS_POW2  = ((SLOTS & (SLOTS - 1)) == 0);

    localparam logic [SLOT_BITS-1:0] SLOT_MAX    = SLOT_BITS'(SLOTS - 1);
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET = LIMIT_W'(768);

    localparam logic [FUNC_W-1:0] FN_GET     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUT     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REPLACE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ADD     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd4;

    typedef struct packed {
        logic              tomb;
        logic [HASH_W-1:0] hi;
        logic [HASH_W-1:0] lo;
    } slot_t;

    typedef struct packed {
        logic                 slot_we;
        logic                 item_we;
        logic [SLOT_BITS-1:0] addr;
        slot_t                slot;
        logic [ITEM_W-1:0]    item;
    } mem_wr_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_CHECK
    } state_t;

endpackage

/* rtl/core/lpht_mem.sv */
module lpht_mem (
    input  logic                            clk,
    input  logic [lpht_pkg::SLOT_BITS-1:0]  rd_addr,
    input  lpht_pkg::mem_wr_t               wr,
    output lpht_pkg::slot_t                 rd_slot,
    output logic [lpht_pkg::ITEM_W-1:0]     rd_item
);

    lpht_pkg::slot_t                 slot_mem [lpht_pkg::SLOTS];
    logic [lpht_pkg::ITEM_W-1:0]     item_mem [lpht_pkg::SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.slot_we)
        begin
            slot_mem[wr.addr] <= wr.slot;
        end
        rd_slot <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.item_we)
        begin
            item_mem[wr.addr] <= wr.item;
        end
        rd_item <= item_mem[rd_addr];
    end

endmodule

/* rtl/core/lpht_ctrl.sv */
module lpht_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [lpht_pkg::FUNC_W-1:0]        func,
    input  logic [lpht_pkg::HASH_W-1:0]        hash_hi,
    input  logic [lpht_pkg::HASH_W-1:0]        hash_lo,
    input  logic [lpht_pkg::IN_ITEM_W-1:0]     new_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [lpht_pkg::OUT_ITEM_W-1:0]    old_item,
    output logic                               added,
    output logic                               full_res,
    output logic [lpht_pkg::COUNT_OUT_W-1:0]   entry_count,
    input  logic                               cfg_we,
    input  logic [lpht_pkg::LIMIT_W-1:0]       cfg_data,
    output logic [lpht_pkg::SLOT_BITS-1:0]     rd_addr,
    output lpht_pkg::mem_wr_t                  wr,
    input  lpht_pkg::slot_t                    rd_slot,
    input  logic [lpht_pkg::ITEM_W-1:0]        rd_item
);

    lpht_pkg::state_t                      state_reg, state_next;
    logic [lpht_pkg::FUNC_W-1:0]           func_reg, func_next;
    logic [lpht_pkg::HASH_W-1:0]           hi_reg, hi_next;
    logic [lpht_pkg::HASH_W-1:0]           lo_reg, lo_next;
    logic [lpht_pkg::ITEM_W-1:0]           item_reg, item_next;
    logic                                  nop_reg, nop_next;
    logic [lpht_pkg::SLOT_BITS-1:0]        addr_reg, addr_next;
    logic [lpht_pkg::SLOT_BITS-1:0]        n_reg, n_next;
    logic [lpht_pkg::CNT_W-1:0]            used_reg, used_next;
    logic [lpht_pkg::CNT_W-1:0]            live_reg, live_next;
    logic [lpht_pkg::LIMIT_W-1:0]          limit_reg;
    logic                                  out_valid_reg, out_valid_next;
    logic                                  out_found_reg, out_added_reg, out_full_reg;
    logic [lpht_pkg::OUT_ITEM_W-1:0]       out_old_reg;
    logic [lpht_pkg::COUNT_OUT_W-1:0]      out_count_reg;

    logic [lpht_pkg::SLOT_BITS-1:0]        addr_inc;
    logic                                  accept;
    logic                                  match;
    logic                                  empty;
    logic                                  live;
    logic                                  room;
    logic                                  probe_end;
    logic                                  out_free;
    logic                                  finish;
    logic                                  step;
    logic                                  res_found, res_added, res_full;
    logic [lpht_pkg::OUT_ITEM_W-1:0]       res_old;

    assign accept    = (state_reg == lpht_pkg::ST_IDLE) && in_valid;
    assign addr_inc  = (addr_reg == lpht_pkg::SLOT_MAX) ? '0 : addr_reg + 1'b1;
    assign match     = (rd_slot.hi == hi_reg) && (rd_slot.lo == lo_reg);
    assign empty     = (rd_slot.hi == '0) && (rd_slot.lo == '0);
    assign live      = match && !rd_slot.tomb;
    assign room      = (lpht_pkg::CMP_W'(used_reg) + 1'b1) < lpht_pkg::CMP_W'(limit_reg);
    assign probe_end = nop_reg || match || empty || (n_reg == lpht_pkg::SLOT_MAX);
    assign out_free  = !out_valid_reg || !out_stall;
    assign finish    = (state_reg == lpht_pkg::ST_CHECK) && probe_end && out_free;
    assign step      = (state_reg == lpht_pkg::ST_CHECK) && !probe_end;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpht_pkg::ST_CLEAR:
            begin
                if (addr_reg == lpht_pkg::SLOT_MAX)
                begin
                    state_next = lpht_pkg::ST_IDLE;
                end
            end
            lpht_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lpht_pkg::ST_PROBE;
                end
            end
            lpht_pkg::ST_PROBE:
            begin
                state_next = lpht_pkg::ST_CHECK;
            end
            lpht_pkg::ST_CHECK:
            begin
                if (finish)
                begin
                    state_next = lpht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::ST_CLEAR;
            end
        endcase
    end

    // request registers, probe address and counters
    always_comb
    begin
        func_next = func_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        item_next = item_reg;
        nop_next  = nop_reg;
        addr_next = addr_reg;
        n_next    = n_reg;
        rd_addr   = addr_reg;
        unique case (state_reg)
            lpht_pkg::ST_CLEAR:
            begin
                addr_next = addr_inc;
            end
            lpht_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    func_next = func;
                    hi_next   = hash_hi;
                    lo_next   = hash_lo;
                    item_next = new_item[lpht_pkg::ITEM_W-1:0];
                    nop_next  = ((hash_hi == '0) && (hash_lo == '0)) || (func > lpht_pkg::FN_REMOVE);
                    addr_next = hash_lo[lpht_pkg::SLOT_BITS-1:0];
                end
            end
            lpht_pkg::ST_PROBE:
            begin
                n_next = '0;
            end
            lpht_pkg::ST_CHECK:
            begin
                if (step)
                begin
                    addr_next = addr_inc;
                    n_next    = n_reg + 1'b1;
                    rd_addr   = addr_inc;
                end
            end
            default:
            begin
                addr_next = '0;
            end
        endcase
    end

    // result and write-back
    always_comb
    begin
        res_found  = 1'b0;
        res_old    = '0;
        res_added  = 1'b0;
        res_full   = 1'b0;
        used_next  = used_reg;
        live_next  = live_reg;
        wr.slot_we = 1'b0;
        wr.item_we = 1'b0;
        wr.addr    = addr_reg;
        wr.slot    = '{tomb: 1'b0, hi: hi_reg, lo: lo_reg};
        wr.item    = item_reg;
        if (state_reg == lpht_pkg::ST_CLEAR)
        begin
            wr.slot_we = 1'b1;
            wr.slot    = '0;
        end
        else if (finish && !nop_reg)
        begin
            unique case (func_reg)
                lpht_pkg::FN_GET:
                begin
                    if (live)
                    begin
                        res_found = 1'b1;
                        res_old   = lpht_pkg::OUT_ITEM_W'(rd_item);
                    end
                end
                lpht_pkg::FN_REPLACE:
                begin
                    if (live)
                    begin
                        res_found  = 1'b1;
                        res_old    = lpht_pkg::OUT_ITEM_W'(rd_item);
                        wr.item_we = 1'b1;
                    end
                end
                lpht_pkg::FN_REMOVE:
                begin
                    if (live)
                    begin
                        res_found    = 1'b1;
                        res_old      = lpht_pkg::OUT_ITEM_W'(rd_item);
                        wr.slot_we   = 1'b1;
                        wr.slot.tomb = 1'b1;
                        live_next    = live_reg - 1'b1;
                    end
                end
                lpht_pkg::FN_PUT, lpht_pkg::FN_ADD:
                begin
                    if (match && rd_slot.tomb)
                    begin
                        wr.slot_we = 1'b1;
                        wr.item_we = 1'b1;
                        live_next  = live_reg + 1'b1;
                        res_added  = 1'b1;
                    end
                    else if (match)
                    begin
                        res_found = 1'b1;
                        if (func_reg == lpht_pkg::FN_PUT)
                        begin
                            res_old    = lpht_pkg::OUT_ITEM_W'(rd_item);
                            wr.item_we = 1'b1;
                        end
                    end
                    else if (empty && room)
                    begin
                        wr.slot_we = 1'b1;
                        wr.item_we = 1'b1;
                        used_next  = used_reg + 1'b1;
                        live_next  = live_reg + 1'b1;
                        res_added  = 1'b1;
                    end
                    else
                    begin
                        res_full = 1'b1;
                    end
                end
                default:
                begin
                    res_found = 1'b0;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        in_stall       = (state_reg != lpht_pkg::ST_IDLE);
        out_valid      = out_valid_reg;
        found          = out_found_reg;
        old_item       = out_old_reg;
        added          = out_added_reg;
        full_res       = out_full_reg;
        entry_count    = out_count_reg;
        out_valid_next = finish || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpht_pkg::ST_CLEAR;
            addr_reg      <= '0;
            n_reg         <= '0;
            nop_reg       <= 1'b0;
            used_reg      <= '0;
            live_reg      <= '0;
            limit_reg     <= lpht_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            n_reg         <= n_next;
            nop_reg       <= nop_next;
            used_reg      <= used_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        item_reg <= item_next;
        if (finish)
        begin
            out_found_reg <= res_found;
            out_old_reg   <= res_old;
            out_added_reg <= res_added;
            out_full_reg  <= res_full;
            out_count_reg <= lpht_pkg::COUNT_OUT_W'(live_next);
        end
    end

    a_live_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= used_reg)
        else $error("live count exceeds used slots");

    a_used_below_slots: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg < lpht_pkg::CNT_W'(lpht_pkg::SLOTS))
        else $error("used slots reached table size");

    a_beat_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == lpht_pkg::ST_CHECK)
        else $error("result beat raised outside probe check");

    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_added_reg && (out_found_reg || out_full_reg)))
        else $error("added together with found or full");

    a_slots_pow2: assert property (@(posedge clk)
        lpht_pkg::SLOTS_POW2)
        else $error("slot count is not a power of two");

endmodule

/* rtl/core/linear_probe_hash_table.sv */
// channel  handshake            payload
// in       in_valid / in_stall  func, hash_hi, hash_lo, new_item
// out      out_valid / out_stall found, old_item, added, full_res, entry_count
// cfg      cfg_we               cfg_data (load_limit)
//
// An item passes through the PROBE and CHECK states, and CHECK steps on to the next slot
// until the probe ends, since the slot memory read is registered; the home slot is the low
// bits of hash_lo, so SLOTS stays a power of two.
// After reset a clearing pass over every slot address empties the slot memory; in_stall
// stays high meanwhile, cfg writes are taken.
// A held result stalls the next item at its last probe step until out_stall drops.
module linear_probe_hash_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [lpht_pkg::FUNC_W-1:0]        func,
    input  logic [lpht_pkg::HASH_W-1:0]        hash_hi,
    input  logic [lpht_pkg::HASH_W-1:0]        hash_lo,
    input  logic [lpht_pkg::IN_ITEM_W-1:0]     new_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [lpht_pkg::OUT_ITEM_W-1:0]    old_item,
    output logic                               added,
    output logic                               full_res,
    output logic [lpht_pkg::COUNT_OUT_W-1:0]   entry_count,
    input  logic                               cfg_we,
    input  logic [lpht_pkg::LIMIT_W-1:0]       cfg_data
);

    logic [lpht_pkg::SLOT_BITS-1:0] rd_addr;
    lpht_pkg::mem_wr_t              wr;
    lpht_pkg::slot_t                rd_slot;
    logic [lpht_pkg::ITEM_W-1:0]    rd_item;

    lpht_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .hash_hi     (hash_hi),
        .hash_lo     (hash_lo),
        .new_item    (new_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .old_item    (old_item),
        .added       (added),
        .full_res    (full_res),
        .entry_count (entry_count),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .rd_addr     (rd_addr),
        .wr          (wr),
        .rd_slot     (rd_slot),
        .rd_item     (rd_item)
    );

    lpht_mem u_mem (
        .clk     (clk),
        .rd_addr (rd_addr),
        .wr      (wr),
        .rd_slot (rd_slot),
        .rd_item (rd_item)
    );

endmodule

/* test/linear_probe_hash_table_tb.sv */
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;

    localparam logic [lpht_pkg::FUNC_W-1:0] FN_NONE_LO = 3'd5;
    localparam logic [lpht_pkg::FUNC_W-1:0] FN_NONE_HI = 3'd7;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                             found;
        logic [lpht_pkg::OUT_ITEM_W-1:0]  old_item;
        logic                             added;
        logic                             full_res;
        logic [lpht_pkg::COUNT_OUT_W-1:0] entry_count;
    } reply_t;

    typedef struct {
        bit                             is_cfg;
        logic [lpht_pkg::LIMIT_W-1:0]   limit;
        logic [lpht_pkg::FUNC_W-1:0]    op;
        logic [lpht_pkg::HASH_W-1:0]    hi;
        logic [lpht_pkg::HASH_W-1:0]    lo;
        logic [lpht_pkg::IN_ITEM_W-1:0] item;
        bit                             typed;
        reply_t                         want;
    } dir_row_t;

    typedef struct {
        logic [lpht_pkg::HASH_W-1:0] hi;
        logic [lpht_pkg::HASH_W-1:0] lo;
    } key_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [lpht_pkg::FUNC_W-1:0]      func;
    logic [lpht_pkg::HASH_W-1:0]      hash_hi;
    logic [lpht_pkg::HASH_W-1:0]      hash_lo;
    logic [lpht_pkg::IN_ITEM_W-1:0]   new_item;
    logic                             out_valid;
    logic                             out_stall;
    logic                             found;
    logic [lpht_pkg::OUT_ITEM_W-1:0]  old_item;
    logic                             added;
    logic                             full_res;
    logic [lpht_pkg::COUNT_OUT_W-1:0] entry_count;
    logic                             cfg_we;
    logic [lpht_pkg::LIMIT_W-1:0]     cfg_data;

    logic [lpht_pkg::HASH_W-1:0] slot_hi [lpht_pkg::SLOTS] = '{default: '0};
    logic [lpht_pkg::HASH_W-1:0] slot_lo [lpht_pkg::SLOTS] = '{default: '0};
    logic [lpht_pkg::ITEM_W-1:0] slot_val [lpht_pkg::SLOTS] = '{default: '0};
    bit                          slot_dead [lpht_pkg::SLOTS] = '{default: 1'b0};
    int unsigned                 used_cnt = 0;
    int unsigned                 live_cnt = 0;
    int unsigned                 load_lim = lpht_pkg::LIMIT_RESET;

    reply_t   pending_replies [$];
    dir_row_t dir_rows [$];
    key_t     key_pool [$];
    int       miscompares = 0;
    int       replies_seen = 0;
    bit       row_typed;
    reply_t   row_want;

    linear_probe_hash_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .hash_hi     (hash_hi),
        .hash_lo     (hash_lo),
        .new_item    (new_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .old_item    (old_item),
        .added       (added),
        .full_res    (full_res),
        .entry_count (entry_count),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic reply_t table_step(input logic [lpht_pkg::FUNC_W-1:0] op,
                                          input logic [lpht_pkg::HASH_W-1:0] hi,
                                          input logic [lpht_pkg::HASH_W-1:0] lo,
                                          input logic [lpht_pkg::IN_ITEM_W-1:0] item);
        reply_t      r;
        int unsigned idx;
        int unsigned n;
        bit          hit;
        bit          hole;
        bit          live;
        r = '0;
        if ((hi != '0 || lo != '0) && op <= lpht_pkg::FN_REMOVE)
        begin
            idx = int'(lo % 64'(lpht_pkg::SLOTS));
            hit = 1'b0;
            hole = 1'b0;
            for (n = 0; n < lpht_pkg::SLOTS && !hit && !hole; n++)
            begin
                if (slot_hi[idx] == hi && slot_lo[idx] == lo)
                    hit = 1'b1;
                else if (slot_hi[idx] == '0 && slot_lo[idx] == '0)
                    hole = 1'b1;
                else
                    idx = (idx + 1) % lpht_pkg::SLOTS;
            end
            live = hit && !slot_dead[idx];
            unique case (op)
                lpht_pkg::FN_GET:
                begin
                    if (live)
                    begin
                        r.found = 1'b1;
                        r.old_item = lpht_pkg::OUT_ITEM_W'(slot_val[idx]);
                    end
                end
                lpht_pkg::FN_REPLACE:
                begin
                    if (live)
                    begin
                        r.found = 1'b1;
                        r.old_item = lpht_pkg::OUT_ITEM_W'(slot_val[idx]);
                        slot_val[idx] = item[lpht_pkg::ITEM_W-1:0];
                    end
                end
                lpht_pkg::FN_REMOVE:
                begin
                    if (live)
                    begin
                        r.found = 1'b1;
                        r.old_item = lpht_pkg::OUT_ITEM_W'(slot_val[idx]);
                        slot_dead[idx] = 1'b1;
                        live_cnt--;
                    end
                end
                default:
                begin
                    if (hit && slot_dead[idx])
                    begin
                        // revive the grave; never refused
                        slot_dead[idx] = 1'b0;
                        slot_val[idx] = item[lpht_pkg::ITEM_W-1:0];
                        live_cnt++;
                        r.added = 1'b1;
                    end
                    else if (hit)
                    begin
                        r.found = 1'b1;
                        if (op == lpht_pkg::FN_PUT)
                        begin
                            r.old_item = lpht_pkg::OUT_ITEM_W'(slot_val[idx]);
                            slot_val[idx] = item[lpht_pkg::ITEM_W-1:0];
                        end
                    end
                    else if (hole && used_cnt + 1 < load_lim)
                    begin
                        slot_hi[idx] = hi;
                        slot_lo[idx] = lo;
                        slot_val[idx] = item[lpht_pkg::ITEM_W-1:0];
                        slot_dead[idx] = 1'b0;
                        used_cnt++;
                        live_cnt++;
                        r.added = 1'b1;
                    end
                    else
                        r.full_res = 1'b1;
                end
            endcase
        end
        r.entry_count = lpht_pkg::COUNT_OUT_W'(live_cnt);
        return r;
    endfunction

    function automatic reply_t reply(input logic f,
                                     input logic [lpht_pkg::OUT_ITEM_W-1:0] old,
                                     input logic a, input logic full,
                                     input logic [lpht_pkg::COUNT_OUT_W-1:0] cnt);
        reply_t r;
        r.found = f;
        r.old_item = old;
        r.added = a;
        r.full_res = full;
        r.entry_count = cnt;
        return r;
    endfunction

    function automatic void op_row(input logic [lpht_pkg::FUNC_W-1:0] op,
                                   input logic [lpht_pkg::HASH_W-1:0] hi,
                                   input logic [lpht_pkg::HASH_W-1:0] lo,
                                   input logic [lpht_pkg::IN_ITEM_W-1:0] item,
                                   input bit typed, input reply_t want);
        dir_row_t r;
        r.is_cfg = 1'b0;
        r.limit = '0;
        r.op = op;
        r.hi = hi;
        r.lo = lo;
        r.item = item;
        r.typed = typed;
        r.want = want;
        dir_rows.push_back(r);
    endfunction

    function automatic void cfg_row(input logic [lpht_pkg::LIMIT_W-1:0] lim);
        dir_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.limit = lim;
        dir_rows.push_back(r);
    endfunction

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (cfg_we)
            load_lim = cfg_data;
        if (out_valid && !out_stall)
        begin
            replies_seen++;
            got = reply(found, old_item, added, full_res, entry_count);
            if (pending_replies.size() == 0)
            begin
                miscompares++;
                if (miscompares <= MAX_REPORTS)
                    $display("%0t: reply with none pending: found=%0d old=%h added=%0d full=%0d count=%0d",
                             $realtime, got.found, got.old_item, got.added, got.full_res,
                             got.entry_count);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.found !== want.found || got.old_item !== want.old_item ||
                    got.added !== want.added || got.full_res !== want.full_res ||
                    got.entry_count !== want.entry_count)
                begin
                    miscompares++;
                    if (miscompares <= MAX_REPORTS)
                        $display("%0t: reply mismatch: want %0d/%h/%0d/%0d/%0d got %0d/%h/%0d/%0d/%0d",
                                 $realtime, want.found, want.old_item, want.added,
                                 want.full_res, want.entry_count, got.found, got.old_item,
                                 got.added, got.full_res, got.entry_count);
                end
            end
        end
        if (in_valid && !in_stall)
        begin
            want = table_step(func, hash_hi, hash_lo, new_item);
            pending_replies.push_back(row_typed ? row_want : want);
        end
    end

    task automatic offer(input logic [lpht_pkg::FUNC_W-1:0] op,
                         input logic [lpht_pkg::HASH_W-1:0] hi,
                         input logic [lpht_pkg::HASH_W-1:0] lo,
                         input logic [lpht_pkg::IN_ITEM_W-1:0] item,
                         input bit typed, input reply_t want, input bit steady);
        while (!steady && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= op;
        hash_hi <= hi;
        hash_lo <= lo;
        new_item <= item;
        row_typed <= typed;
        row_want <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_replies.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_limit(input logic [lpht_pkg::LIMIT_W-1:0] lim);
        drain_replies();
        cfg_we <= 1'b1;
        cfg_data <= lim;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [lpht_pkg::LIMIT_W-1:0] lim, input int beats,
                             input int keys, input int span, input bit steady_mid);
        key_t                           k;
        int unsigned                    base;
        int                             i;
        int                             pick;
        logic [lpht_pkg::FUNC_W-1:0]    op;
        logic [lpht_pkg::IN_ITEM_W-1:0] item;
        set_limit(lim);
        base = $urandom_range(0, lpht_pkg::SLOTS - 1);
        key_pool.delete();
        for (i = 0; i < keys; i++)
        begin
            k.hi = {$urandom, $urandom};
            k.lo = {$urandom, $urandom};
            if (i > 0 && $urandom_range(0, 7) == 0)
                k.lo = key_pool[i - 1].lo;
            else
                k.lo = k.lo - k.lo % lpht_pkg::SLOTS
                     + (base + $urandom_range(0, span - 1)) % lpht_pkg::SLOTS;
            if ($urandom_range(0, 15) == 0)
                k.hi = '0;
            key_pool.push_back(k);
        end
        for (i = 0; i < beats; i++)
        begin
            pick = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, keys - 1)];
            if (pick < 4)
            begin
                k.hi = '0;
                k.lo = '0;
            end
            else if (pick < 9)
            begin
                k.hi = {$urandom, $urandom};
                k.lo = {$urandom, $urandom};
            end
            if ($urandom_range(0, 99) < 4)
                op = lpht_pkg::FUNC_W'($urandom_range(FN_NONE_LO, FN_NONE_HI));
            else
                op = lpht_pkg::FUNC_W'($urandom_range(lpht_pkg::FN_GET, lpht_pkg::FN_REMOVE));
            item = $urandom;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                item = '0;
            else if (pick == 1)
                item = '1;
            if (i == beats / 2)
                drain_replies();
            offer(op, k.hi, k.lo, item, 1'b0, '0,
                  steady_mid && i >= beats / 3 && i < 2 * beats / 3);
        end
    endtask

    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!held && replies_seen >= 150)
            begin
                // hold off long enough for the block to back up into its input
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (replies_seen >= 500 && replies_seen < 650)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 20);
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAIL linear_probe_hash_table");
        $finish;
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = '0;
        hash_hi = '0;
        hash_lo = '0;
        new_item = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        row_typed = 1'b0;
        row_want = '0;

        cfg_row(11'd1);
        op_row(lpht_pkg::FN_GET, '0, '0, '0, 1'b1, reply(1'b0, '0, 1'b0, 1'b0, '0));
        op_row(lpht_pkg::FN_PUT, '0, '0, '1, 1'b1, reply(1'b0, '0, 1'b0, 1'b0, '0));
        op_row(FN_NONE_HI, '1, '1, 32'h1, 1'b1, reply(1'b0, '0, 1'b0, 1'b0, '0));
        op_row(FN_NONE_LO, 64'h1, 64'h5, 32'h2, 1'b1, reply(1'b0, '0, 1'b0, 1'b0, '0));
        op_row(lpht_pkg::FN_PUT, 64'h1, 64'h5, '1, 1'b1, reply(1'b0, '0, 1'b0, 1'b1, '0));
        op_row(lpht_pkg::FN_ADD, 64'h1, 64'h5, 32'h3, 1'b1, reply(1'b0, '0, 1'b0, 1'b1, '0));
        cfg_row(11'd1024);
        op_row(lpht_pkg::FN_PUT, 64'h1, 64'h5, '1, 1'b1,
               reply(1'b0, '0, 1'b1, 1'b0, 11'd1));
        op_row(lpht_pkg::FN_GET, 64'h1, 64'h5, '0, 1'b1,
               reply(1'b1, '1, 1'b0, 1'b0, 11'd1));
        op_row(lpht_pkg::FN_PUT, 64'h1, 64'h5, '0, 1'b1,
               reply(1'b1, '1, 1'b0, 1'b0, 11'd1));
        op_row(lpht_pkg::FN_ADD, 64'h1, 64'h5, 32'h123, 1'b1,
               reply(1'b1, '0, 1'b0, 1'b0, 11'd1));
        op_row(lpht_pkg::FN_REPLACE, 64'h1, 64'h5, 32'h55, 1'b1,
               reply(1'b1, '0, 1'b0, 1'b0, 11'd1));
        op_row(lpht_pkg::FN_ADD, 64'h2, 64'h5, 32'h7, 1'b0, '0);
        op_row(lpht_pkg::FN_PUT, '1, '1, 32'h8000_0000, 1'b0, '0);
        op_row(lpht_pkg::FN_PUT, 64'h3, 64'h3ff, 32'h2, 1'b0, '0);
        op_row(lpht_pkg::FN_REMOVE, 64'h1, 64'h5, '0, 1'b0, '0);
        op_row(lpht_pkg::FN_GET, 64'h2, 64'h5, '0, 1'b0, '0);
        op_row(lpht_pkg::FN_REPLACE, 64'h1, 64'h5, 32'h9, 1'b0, '0);
        op_row(lpht_pkg::FN_REMOVE, 64'h1, 64'h5, '0, 1'b0, '0);
        op_row(lpht_pkg::FN_ADD, 64'h1, 64'h5, 32'h9, 1'b0, '0);
        op_row(lpht_pkg::FN_REPLACE, 64'h4, 64'h6, 32'h11, 1'b0, '0);
        op_row(lpht_pkg::FN_GET, 64'h8000_0000_0000_0000, '0, '0, 1'b0, '0);
        cfg_row(11'd4);
        op_row(lpht_pkg::FN_PUT, 64'h4, 64'h6, 32'h12, 1'b0, '0);
        op_row(lpht_pkg::FN_REMOVE, 64'h2, 64'h5, '0, 1'b0, '0);
        op_row(lpht_pkg::FN_PUT, 64'h2, 64'h5, 32'h13, 1'b0, '0);
        op_row(lpht_pkg::FN_GET, 64'h3, 64'h3ff, '0, 1'b0, '0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].is_cfg)
                set_limit(dir_rows[i].limit);
            else
                offer(dir_rows[i].op, dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].item,
                      dir_rows[i].typed, dir_rows[i].want, 1'b0);
        end

        run_phase(11'd16, 200, 24, 12, 1'b0);
        run_phase(11'd768, 300, 64, 40, 1'b1);
        run_phase(lpht_pkg::LIMIT_W'($urandom_range(40, 1000)), 250, 96, 64, 1'b0);
        run_phase(11'd1024, 150, 48, 24, 1'b0);

        drain_replies();
        repeat (64) @(negedge clk);
        if (miscompares == 0 && pending_replies.size() == 0)
            $display("PASS linear_probe_hash_table");
        else
            $display("FAIL linear_probe_hash_table");
        $finish;
    end

endmodule
